FILE: rtl/core/sapg_pkg.sv
// shared types and constants for the six-axis step pulse generator
// no dependencies; imported by every rtl/core module

package sapg_pkg;

    localparam int JOINTS           = 6;
    localparam int BUFFER_DEPTH_DEF = 32;
    localparam int STEP_BITS_DEF    = 16;

    // packet layout: counts in bytes 2..13 (big-endian pairs), directions in 14..19
    localparam int PKT_LO   = 2;
    localparam int DIR_BYTE = 14;
    localparam int PKT_HI   = 19;

    localparam logic [7:0] END_MARK = 8'h2E;  // '.'
    localparam logic [7:0] POS_MARK = 8'h50;  // 'P'

    typedef enum logic [1:0] {
        OP_RX_BYTE = 2'd0,
        OP_TICK_A  = 2'd1,
        OP_TICK_B  = 2'd2
    } opcode_t;

    typedef struct packed {
        opcode_t    opcode;
        logic [7:0] rx_byte;
    } item_t;

    // one word handed to the processing modules
    typedef struct packed {
        logic       go;
        opcode_t    opcode;
        logic [7:0] rx_byte;
    } step_cmd_t;

endpackage

FILE: rtl/core/six_axis_step_pulse_generator.sv
// top level of the six-axis step pulse generator: input register, result register
// depends on sapg_pkg, sapg_packet, sapg_joints
//
//  channel | direction | tuser                 | tdata
//  --------+-----------+-----------------------+-----------------------------------------
//  s_axis  | in        | [1:0] opcode          | [7:0] rx_byte
//  m_axis  | out       | [0] command_loaded    | [5:0] step_lines [11:6] dir_lines
//          |           |                       | [17:12] busy_mask, [23:18] zero
//
// one word per cycle sustained while m_axis accepts; each word gives exactly one result word
// each word passes through the input register, then through the packet and joint
//   logic into the result register; all state updates land as it is loaded
// synchronous active-low reset zeroes the packet bytes, index, counts, directions,
//   phases and levels; there is no clearing sweep, words are taken right after reset
// a stalled m_axis holds the result register; the input register still fills, so
//   s_axis_tready drops only when both registers hold a word

module six_axis_step_pulse_generator #(
    parameter int BUFFER_DEPTH = sapg_pkg::BUFFER_DEPTH_DEF,
    parameter int STEP_BITS    = sapg_pkg::STEP_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [5:0] step_lines, [11:6] dir_lines, [17:12] busy_mask
    output logic        m_axis_tuser    // [0] command_loaded
);
    import sapg_pkg::*;

    // input register
    logic  in_valid_reg, in_valid_next;
    item_t item_reg, item_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic [JOINTS-1:0] step_reg, dir_reg, busy_reg;
    logic              loaded_reg;

    logic      advance;
    step_cmd_t cmd;

    logic                 load;
    logic [STEP_BITS-1:0] load_cnt [JOINTS];
    logic [JOINTS-1:0]    load_dir;
    logic [JOINTS-1:0]    step_now, dir_now, busy_now;

    // the held word moves on when the result slot is free or being emptied
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        item_next     = item_reg;
        if (advance) begin
            in_valid_next = 1'b0;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            in_valid_next     = 1'b1;
            item_next.opcode  = opcode_t'(s_axis_tuser);
            item_next.rx_byte = s_axis_tdata;
        end
        out_valid_next = out_valid_reg;
        if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end
    end

    assign cmd.go      = advance;
    assign cmd.opcode  = item_reg.opcode;
    assign cmd.rx_byte = item_reg.rx_byte;

    sapg_packet #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .STEP_BITS    (STEP_BITS)
    ) u_packet (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .load_o  (load),
        .cnt_o   (load_cnt),
        .dir_o   (load_dir)
    );

    sapg_joints #(
        .STEP_BITS (STEP_BITS)
    ) u_joints (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .load_i  (load),
        .cnt_i   (load_cnt),
        .dir_i   (load_dir),
        .step_o  (step_now),
        .dir_o   (dir_now),
        .busy_o  (busy_now)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        if (advance) begin
            step_reg   <= step_now;
            dir_reg    <= dir_now;
            busy_reg   <= busy_now;
            loaded_reg <= load;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, busy_reg, dir_reg, step_reg};
    assign m_axis_tuser  = loaded_reg;

    // a loaded flag can only come from a received end-of-packet byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (item_reg.opcode != OP_RX_BYTE) |=> !loaded_reg)
        else $error("command_loaded raised by a timer tick");

    // every processed word lands in the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("processed word lost before the result register");

    // input side stalls only with both stages full and the output blocked
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without back-pressure");

endmodule

FILE: rtl/core/sapg_packet.sv
// packet buffer: byte index, stored command bytes and packet decode
// depends on sapg_pkg

module sapg_packet #(
    parameter int BUFFER_DEPTH = sapg_pkg::BUFFER_DEPTH_DEF,
    parameter int STEP_BITS    = sapg_pkg::STEP_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sapg_pkg::step_cmd_t   cmd,
    output logic                  load_o,
    output logic [STEP_BITS-1:0]  cnt_o [sapg_pkg::JOINTS],
    output logic [sapg_pkg::JOINTS-1:0] dir_o
);
    import sapg_pkg::*;

    localparam int IDX_W = $clog2(BUFFER_DEPTH + 1);

    logic [IDX_W-1:0] idx_reg, idx_next;
    // only bytes 2..19 are ever decoded, the rest of the buffer is not kept
    logic [7:0] pkt_reg  [PKT_LO:PKT_HI];
    logic [7:0] pkt_next [PKT_LO:PKT_HI];
    logic       wr;

    always_comb begin
        logic [STEP_BITS+15:0] wide;
        wr = cmd.go && (cmd.opcode == OP_RX_BYTE) && (idx_reg != IDX_W'(BUFFER_DEPTH));
        pkt_next = pkt_reg;
        for (int k = PKT_LO; k <= PKT_HI; k++) begin
            if (wr && (idx_reg == IDX_W'(k))) begin
                pkt_next[k] = cmd.rx_byte;
            end
        end
        idx_next = idx_reg;
        if (wr) begin
            idx_next = idx_reg + IDX_W'(1);
        end
        load_o = cmd.go && (cmd.opcode == OP_RX_BYTE) && (cmd.rx_byte == END_MARK);
        if (load_o) begin
            idx_next = '0;
        end
        // decode sees the terminating byte if it landed inside the packet
        for (int j = 0; j < JOINTS; j++) begin
            wide     = {{STEP_BITS{1'b0}}, pkt_next[PKT_LO + 2*j], pkt_next[PKT_LO + 2*j + 1]};
            cnt_o[j] = wide[STEP_BITS-1:0];
            dir_o[j] = (pkt_next[DIR_BYTE + j] == POS_MARK);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            for (int k = PKT_LO; k <= PKT_HI; k++) begin
                pkt_reg[k] <= '0;
            end
        end else begin
            idx_reg <= idx_next;
            pkt_reg <= pkt_next;
        end
    end

endmodule

FILE: rtl/core/sapg_joints.sv
// joint state: remaining counts, directions, timer phases and step levels
// depends on sapg_pkg

module sapg_joints #(
    parameter int STEP_BITS = sapg_pkg::STEP_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sapg_pkg::step_cmd_t         cmd,
    input  logic                        load_i,
    input  logic [STEP_BITS-1:0]        cnt_i [sapg_pkg::JOINTS],
    input  logic [sapg_pkg::JOINTS-1:0] dir_i,
    output logic [sapg_pkg::JOINTS-1:0] step_o,
    output logic [sapg_pkg::JOINTS-1:0] dir_o,
    output logic [sapg_pkg::JOINTS-1:0] busy_o
);
    import sapg_pkg::*;

    logic [STEP_BITS-1:0] cnt_reg  [JOINTS];
    logic [STEP_BITS-1:0] cnt_next [JOINTS];
    logic [JOINTS-1:0]    dir_reg, dir_next;
    logic [JOINTS-1:0]    lvl_reg, lvl_next;
    logic                 phase_a_reg, phase_a_next;
    logic                 phase_b_reg, phase_b_next;
    logic [JOINTS-1:0]    drive;
    logic                 high;

    always_comb begin
        drive        = '0;
        high         = 1'b0;
        phase_a_next = phase_a_reg;
        phase_b_next = phase_b_reg;
        if (cmd.go) begin
            unique case (cmd.opcode)
                OP_TICK_A: begin
                    drive        = JOINTS'(1);
                    high         = phase_a_reg;
                    phase_a_next = ~phase_a_reg;
                end
                OP_TICK_B: begin
                    drive        = ~JOINTS'(1);
                    high         = phase_b_reg;
                    phase_b_next = ~phase_b_reg;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        dir_next = dir_reg;
        lvl_next = lvl_reg;
        if (load_i) begin
            cnt_next = cnt_i;
            dir_next = dir_i;
        end
        for (int j = 0; j < JOINTS; j++) begin
            if (drive[j]) begin
                if (!high) begin
                    lvl_next[j] = 1'b0;
                end else if (cnt_reg[j] != '0) begin
                    lvl_next[j] = 1'b1;
                    cnt_next[j] = cnt_reg[j] - STEP_BITS'(1);
                end
            end
        end
        for (int j = 0; j < JOINTS; j++) begin
            busy_o[j] = |cnt_next[j];
        end
    end

    assign step_o = lvl_next;
    assign dir_o  = dir_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < JOINTS; j++) begin
                cnt_reg[j] <= '0;
            end
            dir_reg     <= '0;
            lvl_reg     <= '0;
            phase_a_reg <= 1'b0;
            phase_b_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            dir_reg     <= dir_next;
            lvl_reg     <= lvl_next;
            phase_a_reg <= phase_a_next;
            phase_b_reg <= phase_b_next;
        end
    end

endmodule

FILE: dv/tb_top.sv
// self-checking testbench for six_axis_step_pulse_generator: directed rows, then random packets
// depends on sapg_pkg and the rtl/core sources; predicts every result word in-line
`timescale 1ns / 1ps

module tb_top;
    import sapg_pkg::*;

    // unused opcode value, not a member of opcode_t
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_WORDS = 1200;
    localparam int PHASES       = 4;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off, fills both rtl registers
    localparam int QUIET_LIMIT  = 3000;  // cycles with no word moving on either side
    localparam int DRAIN_CYCLES = 8;     // margin after the last expected word, to catch strays
    localparam int NUM_ROWS     = 27;

    // one result word, unpacked from m_axis
    typedef struct packed {
        logic [5:0] steps;
        logic [5:0] dirs;
        logic       loaded;
        logic [5:0] busy;
    } pulse_out_t;

    // one directed row: the word to send and, where typed, the result it must give
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic       typed;
        pulse_out_t want;
    } stim_row_t;

    localparam pulse_out_t RESET_OUT = '0;
    localparam pulse_out_t UNTYPED   = '0;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] rx_byte
    logic [1:0]  s_axis_tuser  = 2'd0;   // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // [5:0] step_lines, [11:6] dir_lines, [17:12] busy_mask
    logic        m_axis_tuser;           // [0] command_loaded

    // predictor state, mirrors the block after every accepted input word
    logic [7:0]               pkt_bytes [BUFFER_DEPTH_DEF];
    int                       pkt_fill;
    logic [STEP_BITS_DEF-1:0] step_count [JOINTS];
    logic [5:0]               dir_bits;
    logic                     phase_a;
    logic                     phase_b;
    logic [5:0]               level_bits;

    // expected result words, oldest first
    pulse_out_t pending_levels [$];

    int mismatches    = 0;
    int words_sent    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    stim_row_t directed_rows [NUM_ROWS];

    six_axis_step_pulse_generator uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // one timer tick on joints lo..hi: high phase steps nonzero counts, low phase clears lines
    function automatic void pulse_joints(input int lo, input int hi, input logic high_phase);
        for (int j = lo; j <= hi; j++) begin
            if (high_phase) begin
                if (step_count[j] != '0) begin
                    level_bits[j] = 1'b1;
                    step_count[j] = step_count[j] - 1'b1;
                end
            end else begin
                level_bits[j] = 1'b0;
            end
        end
    endfunction

    // advance the predictor by one input word and return the pulse outputs it leaves
    function automatic pulse_out_t compute_pulse_state(input logic [1:0] op,
                                                       input logic [7:0] data);
        pulse_out_t r;
        r = '0;
        case (op)
            OP_RX_BYTE: begin
                // a full store drops the byte, but an end mark still completes the packet
                if (pkt_fill < BUFFER_DEPTH_DEF) begin
                    pkt_bytes[pkt_fill] = data;
                    pkt_fill++;
                end
                if (data == END_MARK) begin
                    // store is not cleared, stale bytes are loaded as they stand
                    pkt_fill = 0;
                    dir_bits = '0;
                    for (int j = 0; j < JOINTS; j++) begin
                        step_count[j] = {pkt_bytes[PKT_LO + 2 * j], pkt_bytes[PKT_LO + 2 * j + 1]};
                        if (pkt_bytes[DIR_BYTE + j] == POS_MARK)
                            dir_bits[j] = 1'b1;
                    end
                    r.loaded = 1'b1;
                end
            end
            OP_TICK_A: begin
                pulse_joints(0, 0, phase_a);
                phase_a = ~phase_a;
            end
            OP_TICK_B: begin
                pulse_joints(1, JOINTS - 1, phase_b);
                phase_b = ~phase_b;
            end
            default: ;  // unused opcode leaves the state alone
        endcase
        r.steps = level_bits;
        r.dirs  = dir_bits;
        for (int j = 0; j < JOINTS; j++)
            r.busy[j] = (step_count[j] != '0);
        return r;
    endfunction

    // random byte that never ends a packet
    function automatic logic [7:0] rand_plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == END_MARK);
        return b;
    endfunction

    // offer one word, with random idle cycles first, and record its prediction once taken
    task automatic send_word(input logic [1:0] op, input logic [7:0] data, input logic typed,
                             input pulse_out_t want);
        pulse_out_t got;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
        got = compute_pulse_state(op, data);
        pending_levels.push_back(typed ? want : got);
        if (op != OP_UNUSED)
            words_sent++;
    endtask

    // one random burst: mostly a well-formed packet followed by ticks,
    // otherwise a broken packet (short, or long enough to fill the store) or plain noise
    task automatic send_random_burst();
        int         kind;
        int         n;
        logic [7:0] hi;
        logic [7:0] lo;
        logic [1:0] op;
        kind = $urandom_range(99);
        if (kind < 70) begin
            send_word(OP_RX_BYTE, rand_plain_byte(), 1'b0, UNTYPED);
            send_word(OP_RX_BYTE, rand_plain_byte(), 1'b0, UNTYPED);
            // counts mostly small so that ticks drain them, now and then a wide one
            for (int j = 0; j < JOINTS; j++) begin
                if ($urandom_range(9) == 0) begin
                    hi = rand_plain_byte();
                    lo = rand_plain_byte();
                end else begin
                    hi = 8'h00;
                    lo = 8'($urandom_range(6));
                end
                send_word(OP_RX_BYTE, hi, 1'b0, UNTYPED);
                send_word(OP_RX_BYTE, lo, 1'b0, UNTYPED);
            end
            for (int j = 0; j < JOINTS; j++)
                send_word(OP_RX_BYTE, ($urandom_range(9) < 6) ? POS_MARK : rand_plain_byte(),
                          1'b0, UNTYPED);
            send_word(OP_RX_BYTE, END_MARK, 1'b0, UNTYPED);
            n = $urandom_range(30, 4);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(19) == 0)
                    op = OP_UNUSED;
                else
                    op = $urandom_range(1) ? OP_TICK_A : OP_TICK_B;
                send_word(op, 8'($urandom_range(255)), 1'b0, UNTYPED);
            end
        end else if (kind < 85) begin
            // any byte, end marks included; beyond the store size the index saturates
            n = $urandom_range(40);
            for (int k = 0; k < n; k++)
                send_word(OP_RX_BYTE, 8'($urandom_range(255)), 1'b0, UNTYPED);
            send_word(OP_RX_BYTE, END_MARK, 1'b0, UNTYPED);
        end else begin
            n = $urandom_range(10, 1);
            for (int k = 0; k < n; k++)
                send_word(2'($urandom_range(3)), 8'($urandom_range(255)), 1'b0, UNTYPED);
        end
    endtask

    // compare one field of a result word
    task automatic report_field(input string what, input logic [7:0] want, input logic [7:0] seen);
        if (want !== seen) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, seen);
        end
    endtask

    // receiver: random stalls, a long hold-off on request, and the result check
    always @(posedge aclk) begin
        pulse_out_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_levels.size() == 0) begin
                    mismatches++;
                    $display("%0t: result word %0h with none expected, expected nothing, actual %0h",
                             $time, m_axis_tdata, m_axis_tdata);
                end else begin
                    want = pending_levels.pop_front();
                    report_field("step_lines", 8'(want.steps), 8'(m_axis_tdata[5:0]));
                    report_field("dir_lines", 8'(want.dirs), 8'(m_axis_tdata[11:6]));
                    report_field("busy_mask", 8'(want.busy), 8'(m_axis_tdata[17:12]));
                    report_field("tdata padding", 8'h00, 8'(m_axis_tdata[23:18]));
                    report_field("command_loaded", 8'(want.loaded), 8'(m_axis_tuser));
                end
            end
            // hold-off counted here while the sender keeps offering words
            if (hold_req != hold_seen) begin
                hold_seen     <= hold_req;
                hold_left     <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // watchdog: ends the run when no word moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    // main sequence
    initial begin
        int target;

        // directed rows: reset state, a full packet with extreme bytes, then both timers
        directed_rows = '{
            // reset state: a tick in the low phase and the unused opcode report all zero
            '{OP_TICK_A,  8'h00, 1'b1, RESET_OUT},
            '{OP_UNUSED,  8'hFF, 1'b1, RESET_OUT},
            // header bytes 0 and 1
            '{OP_RX_BYTE, 8'h00, 1'b0, UNTYPED},
            '{OP_RX_BYTE, 8'hFF, 1'b0, UNTYPED},
            // counts: 2, ffff, 1, 8000, 0, 1
            '{OP_RX_BYTE, 8'h00, 1'b0, UNTYPED},
            '{OP_RX_BYTE, 8'h02, 1'b0, UNTYPED},
            '{OP_RX_BYTE, 8'hFF, 1'b0, UNTYPED},
            '{OP_RX_BYTE, 8'hFF, 1'b0, UNTYPED},
            '{OP_RX_BYTE, 8'h00, 1'b0, UNTYPED},
            '{OP_RX_BYTE, 8'h01, 1'b0, UNTYPED},
            '{OP_RX_BYTE, 8'h80, 1'b0, UNTYPED},
            '{OP_RX_BYTE, 8'h00, 1'b0, UNTYPED},
            '{OP_RX_BYTE, 8'h00, 1'b0, UNTYPED},
            '{OP_RX_BYTE, 8'h00, 1'b0, UNTYPED},
            '{OP_RX_BYTE, 8'h00, 1'b0, UNTYPED},
            '{OP_RX_BYTE, 8'h01, 1'b0, UNTYPED},
            // directions: only an upper-case P counts as positive
            '{OP_RX_BYTE, POS_MARK, 1'b0, UNTYPED},
            '{OP_RX_BYTE, 8'h4E,    1'b0, UNTYPED},
            '{OP_RX_BYTE, POS_MARK, 1'b0, UNTYPED},
            '{OP_RX_BYTE, POS_MARK, 1'b0, UNTYPED},
            '{OP_RX_BYTE, 8'h70,    1'b0, UNTYPED},
            '{OP_RX_BYTE, 8'hFF,    1'b0, UNTYPED},
            // end mark loads joints 0,2,3 positive, joint 4 idle
            '{OP_RX_BYTE, END_MARK, 1'b1, '{6'b000000, 6'b001101, 1'b1, 6'b101111}},
            // timer a now in its high phase, then low
            '{OP_TICK_A,  8'hFF, 1'b0, UNTYPED},
            '{OP_TICK_A,  8'h00, 1'b0, UNTYPED},
            // timer b low, then high: joint 4 has a zero count and keeps its line
            '{OP_TICK_B,  8'hFF, 1'b0, UNTYPED},
            '{OP_TICK_B,  8'h00, 1'b0, UNTYPED}
        };

        // predictor starts from the reset state
        for (int i = 0; i < BUFFER_DEPTH_DEF; i++)
            pkt_bytes[i] = 8'h00;
        for (int j = 0; j < JOINTS; j++)
            step_count[j] = '0;
        pkt_fill   = 0;
        dir_bits   = '0;
        phase_a    = 1'b0;
        phase_b    = 1'b0;
        level_bits = '0;

        // reset held from the start, released once
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < NUM_ROWS; r++)
            send_word(directed_rows[r].op, directed_rows[r].data, directed_rows[r].typed,
                      directed_rows[r].want);

        // random part in phases: no idling, sender idle, receiver stalling, both
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 79; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 79; end
                default: begin send_idle_pct = 13; stall_pct = 13; end
            endcase
            // long receiver hold-off while the sender keeps pushing
            if (phase == 0)
                hold_req++;
            target = words_sent + RANDOM_WORDS / PHASES;
            while (words_sent < target)
                send_random_burst();
        end
        s_axis_tvalid <= 1'b0;

        // wait for every expected word, then a few more cycles for strays
        while (pending_levels.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && pending_levels.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
